[rtl/tpc_pkg.sv]
// shared types and constants for the temperature/pressure compensation block
`timescale 1ns / 1ps
package tpc_pkg;

    localparam int CalWidth = 48;
    localparam int RegIdxWidth = 2;

    localparam logic [RegIdxWidth-1:0] REG_CAL_TEMP    = 2'd0;
    localparam logic [RegIdxWidth-1:0] REG_CAL_PRESS_A = 2'd1;
    localparam logic [RegIdxWidth-1:0] REG_CAL_PRESS_B = 2'd2;
    localparam logic [RegIdxWidth-1:0] REG_CAL_PRESS_C = 2'd3;

    localparam logic [31:0] OFFS_64000  = 32'd64000;
    localparam logic [31:0] CONST_2P20  = 32'd1048576;
    localparam logic [31:0] CONST_3125  = 32'd3125;
    localparam logic [31:0] CONST_32768 = 32'd32768;
    localparam logic [31:0] CONST_128   = 32'd128;

    typedef struct packed {
        logic        func;
        logic [23:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic signed [31:0] temperature;
        logic [31:0] pressure;
        logic        div_zero;
    } out_item_t;

    // sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
        ST_P8, ST_P9, ST_PDIV, ST_PWAIT, ST_P10, ST_P11, ST_P12, ST_P13,
        ST_DONE
    } state_t;

    // divider control/status bundle
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] quotient;
    } div_rsp_t;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        logic signed [31:0] t;
        t = v;
        return 32'(t >>> s);
    endfunction

    // sign-extend 16-bit calibration word
    function automatic logic [31:0] sx16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

endpackage

[rtl/tpc_mul.sv]
// shared 32x32 multiplier keeping low 32 bits, registered output
`timescale 1ns / 1ps
module tpc_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    logic [31:0] p_reg;

    // wrapping product
    always_ff @(posedge clk)
    begin
        p_reg <= 32'(a * b);
    end

    assign p = p_reg;
endmodule

[rtl/tpc_div.sv]
// 32-bit unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tpc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tpc_pkg::div_req_t req,
    output tpc_pkg::div_rsp_t rsp
);
    import tpc_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        trial = {rem_reg[31:0], quo_reg[31]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            cnt_next = 6'd32;
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = (cnt_reg != 6'd0);
    assign rsp.quotient = quo_reg;

    // a start always loads a full count
    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> cnt_reg == 6'd32)
        else $error("divider count not loaded");
    // count only falls by one while running
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 6'd0 && !req.start) |=> cnt_reg == $past(cnt_reg) - 6'd1)
        else $error("divider count skipped");
    // remainder stays below divisor once done
    assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(rsp.busy) && dvs_reg != 32'd0) |-> rem_reg < {1'b0, dvs_reg})
        else $error("divider remainder out of range");
endmodule

[rtl/temp_pressure_compensation.sv]
// top level: sequencer around a shared multiplier and divider
// throughput: one transaction at a time; in_stall high after accept until the
// result is taken; the shared multiplier and the bit-serial divider set the rate
// reset: calibration registers and fine temperature cleared, sequencer idle
`timescale 1ns / 1ps
module temp_pressure_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tpc_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tpc_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [tpc_pkg::RegIdxWidth-1:0]   cfg_index,
    input  logic [tpc_pkg::CalWidth-1:0]      cfg_data
);
    import tpc_pkg::*;

    state_t      state_reg, state_next;
    logic [47:0] cal_t_reg, cal_a_reg, cal_b_reg, cal_c_reg;
    logic [31:0] fine_reg, fine_next;
    logic [19:0] adc_reg, adc_next;
    logic        func_reg, func_next;
    logic [31:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [31:0] ma, mb, prod;
    out_item_t   res_reg, res_next;
    logic        ov_reg, ov_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] adc32;

    assign t1 = {16'd0, cal_t_reg[15:0]};
    assign t2 = sx16(cal_t_reg[31:16]);
    assign t3 = sx16(cal_t_reg[47:32]);
    assign p1 = {16'd0, cal_a_reg[15:0]};
    assign p2 = sx16(cal_a_reg[31:16]);
    assign p3 = sx16(cal_a_reg[47:32]);
    assign p4 = sx16(cal_b_reg[15:0]);
    assign p5 = sx16(cal_b_reg[31:16]);
    assign p6 = sx16(cal_b_reg[47:32]);
    assign p7 = sx16(cal_c_reg[15:0]);
    assign p8 = sx16(cal_c_reg[31:16]);
    assign p9 = sx16(cal_c_reg[47:32]);
    assign adc32 = {12'd0, adc_reg};

    tpc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));
    tpc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t_reg <= '0;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAL_TEMP:    cal_t_reg <= cfg_data;
                REG_CAL_PRESS_A: cal_a_reg <= cfg_data;
                REG_CAL_PRESS_B: cal_b_reg <= cfg_data;
                REG_CAL_PRESS_C: cal_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: x,y,z are scratch; product is registered and arrives in the cycle after issue
    always_comb
    begin
        state_next = state_reg;
        fine_next  = fine_reg;
        adc_next   = adc_reg;
        func_next  = func_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        ma = '0;
        mb = '0;
        dreq.start = 1'b0;
        dreq.dividend = z_reg;
        dreq.divisor = x_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    adc_next = in_data.raw_sample[23:4];
                    func_next = in_data.func;
                    state_next = in_data.func ? ST_P0 : ST_T0;
                end
            end
            // temperature path
            ST_T0:
            begin
                ma = {15'd0, adc_reg[19:3]} - (t1 << 1);
                mb = t2;
                x_next = {16'd0, adc_reg[19:4]} - t1;
                state_next = ST_T1;
            end
            ST_T1:
            begin
                y_next = asr(prod, 11);
                ma = x_reg;
                mb = x_reg;
                state_next = ST_T2;
            end
            ST_T2:
            begin
                ma = asr(prod, 12);
                mb = t3;
                state_next = ST_T3;
            end
            ST_T3:
            begin
                fine_next = y_reg + asr(prod, 14);
                state_next = ST_T4;
            end
            ST_T4:
            begin
                res_next.kind = 1'b0;
                res_next.temperature = asr(fine_reg * 32'd5 + CONST_128, 8);
                res_next.pressure = '0;
                res_next.div_zero = 1'b0;
                state_next = ST_DONE;
            end
            // pressure path: x=v1, y=q
            ST_P0:
            begin
                x_next = asr(fine_reg, 1) - OFFS_64000;
                y_next = asr(asr(fine_reg, 1) - OFFS_64000, 2);
                state_next = ST_P1;
            end
            ST_P1:
            begin
                ma = y_reg;
                mb = y_reg;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                y_next = prod;
                ma = asr(prod, 11);
                mb = p6;
                state_next = ST_P3;
            end
            ST_P3:
            begin
                z_next = prod;
                ma = x_reg;
                mb = p5;
                state_next = ST_P4;
            end
            ST_P4:
            begin
                z_next = asr(z_reg + (prod << 1), 2) + (p4 << 16);
                ma = p3;
                mb = asr(y_reg, 13);
                state_next = ST_P5;
            end
            ST_P5:
            begin
                y_next = asr(prod, 3);
                ma = p2;
                mb = x_reg;
                state_next = ST_P6;
            end
            ST_P6:
            begin
                x_next = asr(y_reg + asr(prod, 1), 18);
                state_next = ST_P7;
            end
            ST_P7:
            begin
                ma = CONST_32768 + x_reg;
                mb = p1;
                state_next = ST_P8;
            end
            ST_P8:
            begin
                x_next = asr(prod, 15);
                ma = (CONST_2P20 - adc32) - asr(z_reg, 12);
                mb = CONST_3125;
                state_next = ST_P9;
            end
            ST_P9:
            begin
                y_next = prod;
                if (x_reg == 32'd0)
                begin
                    res_next.kind = 1'b1;
                    res_next.temperature = '0;
                    res_next.pressure = '0;
                    res_next.div_zero = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    z_next = prod[31] ? prod : (prod << 1);
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                dreq.start = 1'b1;
                state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (!drsp.busy)
                begin
                    z_next = y_reg[31] ? (drsp.quotient << 1) : drsp.quotient;
                    state_next = ST_P10;
                end
            end
            // z = p
            ST_P10:
            begin
                ma = {3'd0, z_reg[31:3]};
                mb = {3'd0, z_reg[31:3]};
                state_next = ST_P11;
            end
            ST_P11:
            begin
                ma = p9;
                mb = prod >> 13;
                state_next = ST_P12;
            end
            ST_P12:
            begin
                x_next = asr(prod, 12);
                ma = z_reg >> 2;
                mb = p8;
                state_next = ST_P13;
            end
            ST_P13:
            begin
                res_next.kind = 1'b1;
                res_next.temperature = '0;
                res_next.pressure = z_reg + asr(x_reg + asr(prod, 13) + p7, 4);
                res_next.div_zero = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fine_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fine_reg <= fine_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_reg <= adc_next;
        func_reg <= func_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        res_reg <= res_next;
    end

    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data = res_reg;

    // result kind matches the accepted func
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> res_reg.kind == func_reg)
        else $error("result kind mismatch");
    // fine temperature only changes on the temperature path
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_T3) |=> $stable(fine_reg))
        else $error("fine temperature written off path");
    // divide never starts with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> x_reg != 32'd0)
        else $error("divide by zero issued");
    // temperature results carry no pressure and no divide-by-zero flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res_reg.kind) |-> (res_reg.pressure == 32'd0 && !res_reg.div_zero))
        else $error("temperature result has pressure");
endmodule
